// ===== rtl/dhkt_pkg.sv =====
// ----------------------------------------------------------------------------
// dhkt_pkg
// Shared types and constants for the double-hashing key table: request and
// result payloads, status codes, and the controller/datapath command bundles.
// ----------------------------------------------------------------------------
package dhkt_pkg;

    localparam int TABLE_SLOTS_DEF = 127;

    localparam int KEY_W     = 31;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int ENTRIES_W = 7;

    // reciprocal multiply, then remainder; final correction at probe set-up
    localparam int HASH_STEPS = 2;
    localparam int HASH_CNT_W = $clog2(HASH_STEPS);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_MISS = 2'd2
    } status_t;

    typedef struct packed {
        logic                mode;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [VALUE_W-1:0]   value_out;
        logic [ENTRIES_W-1:0] entries_used;
    } result_t;

    typedef struct packed {
        logic    clear_wr;
        logic    load;
        logic    hash_step;
        logic    probe_init;
        logic    mem_rd;
        logic    write;
        logic    advance;
        logic    finish;
        status_t res_status;
        logic    res_hit;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic hash_last;
        logic refuse;
        logic is_search;
        logic slot_empty;
        logic slot_match;
        logic probe_last;
    } dp_status_t;

endpackage

// ===== rtl/dhkt_datapath.sv =====
// ----------------------------------------------------------------------------
// dhkt_datapath
// Slot memory, key reduction (mod N and mod N-1) by reciprocal multiply,
// probe index arithmetic, occupancy count and the registered result.
// ----------------------------------------------------------------------------
module dhkt_datapath #(
    parameter int TABLE_SLOTS = dhkt_pkg::TABLE_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dhkt_pkg::request_t    request,
    input  dhkt_pkg::dp_cmd_t     cmd,
    output dhkt_pkg::dp_status_t  stat,
    output logic                  result_valid,
    output dhkt_pkg::result_t     result
);
    import dhkt_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_SLOTS);
    localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
    localparam int REM_W   = IDX_W + 1;
    localparam int RECIP_W = 32;
    localparam int PROD_W  = KEY_W + RECIP_W;

    localparam logic [REM_W-1:0] SLOTS_R   = REM_W'(TABLE_SLOTS);
    localparam logic [REM_W-1:0] SLOTS_M_R = REM_W'(TABLE_SLOTS - 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOTS_C   = CNT_W'(TABLE_SLOTS);
    localparam logic [CNT_W-1:0] LAST_PROBE = CNT_W'(TABLE_SLOTS - 1);
    localparam logic [HASH_CNT_W-1:0] HASH_LAST = HASH_CNT_W'(HASH_STEPS - 1);
    localparam logic [RECIP_W-1:0] RECIP_N =
        RECIP_W'((64'd1 << RECIP_W) / TABLE_SLOTS);
    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'((64'd1 << RECIP_W) / (TABLE_SLOTS - 1));

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

    entry_t mem [TABLE_SLOTS];
    entry_t rd_data_reg;

    logic                  mode_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic [HASH_CNT_W-1:0] hash_cnt_reg;
    logic [PROD_W-1:0]     prod_n;
    logic [PROD_W-1:0]     prod_m;
    logic [KEY_W-1:0]      quo_n_reg;
    logic [KEY_W-1:0]      quo_m_reg;
    logic [REM_W-1:0]      rem_n_reg;
    logic [REM_W-1:0]      rem_m_reg;
    logic [REM_W-1:0]      rem_n_fix;
    logic [REM_W-1:0]      rem_m_fix;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      step_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [IDX_W:0]        idx_sum;
    logic [CNT_W-1:0]      probe_cnt_reg;
    logic [IDX_W-1:0]      clr_addr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  result_valid_reg;
    result_t               result_reg;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    entry_t                wr_data;

    // quotient estimate is exact or one low, so the remainder is below 2N
    assign prod_n = PROD_W'(key_reg) * PROD_W'(RECIP_N);
    assign prod_m = PROD_W'(key_reg) * PROD_W'(RECIP_M);

    always_comb
    begin
        rem_n_fix = rem_n_reg;
        if (rem_n_reg >= SLOTS_R)
        begin
            rem_n_fix = rem_n_reg - SLOTS_R;
        end
        rem_m_fix = rem_m_reg;
        if (rem_m_reg >= SLOTS_M_R)
        begin
            rem_m_fix = rem_m_reg - SLOTS_M_R;
        end
    end

    always_comb
    begin
        idx_sum = {1'b0, idx_reg} + {1'b0, step_reg};
        if (idx_sum >= SLOTS_R)
        begin
            idx_sum = idx_sum - SLOTS_R;
        end
        idx_next = idx_sum[IDX_W-1:0];
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.write && !rd_data_reg.valid)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    assign wr_en   = cmd.clear_wr | cmd.write;
    assign wr_addr = cmd.clear_wr ? clr_addr_reg : idx_reg;
    assign wr_data = cmd.clear_wr ? entry_t'('0) : entry_t'{1'b1, key_reg, value_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg     <= request.mode;
            key_reg      <= request.key;
            value_reg    <= request.value;
            hash_cnt_reg <= '0;
        end
        else if (cmd.hash_step)
        begin
            hash_cnt_reg <= hash_cnt_reg + HASH_CNT_W'(1);
            quo_n_reg    <= prod_n[PROD_W-1:RECIP_W];
            quo_m_reg    <= prod_m[PROD_W-1:RECIP_W];
            rem_n_reg    <= key_reg[REM_W-1:0] - quo_n_reg[REM_W-1:0] * SLOTS_R;
            rem_m_reg    <= key_reg[REM_W-1:0] - quo_m_reg[REM_W-1:0] * SLOTS_M_R;
        end

        if (cmd.probe_init)
        begin
            idx_reg       <= rem_n_fix[IDX_W-1:0];
            step_reg      <= rem_m_fix[IDX_W-1:0] + IDX_W'(1);
            probe_cnt_reg <= '0;
        end
        else if (cmd.advance)
        begin
            idx_reg       <= idx_next;
            probe_cnt_reg <= probe_cnt_reg + CNT_W'(1);
        end

        if (cmd.finish)
        begin
            result_reg.status       <= cmd.res_status;
            result_reg.value_out    <= cmd.res_hit ? rd_data_reg.value : '0;
            result_reg.entries_used <= ENTRIES_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg     <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            end
            count_reg        <= count_next;
            result_valid_reg <= cmd.finish;
        end
    end

    assign stat.clear_last = (clr_addr_reg == LAST_IDX);
    assign stat.hash_last  = (hash_cnt_reg == HASH_LAST);
    assign stat.refuse     = (mode_reg == MODE_INSERT) && (count_reg >= SLOTS_C);
    assign stat.is_search  = (mode_reg == MODE_SEARCH);
    assign stat.slot_empty = !rd_data_reg.valid;
    assign stat.slot_match = (rd_data_reg.key == key_reg);
    assign stat.probe_last = (probe_cnt_reg == LAST_PROBE);

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/dhkt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dhkt_ctrl
// Sequencer: clearing pass after reset, key reduction, then one memory read
// and one check per probe until the request is resolved.
// ----------------------------------------------------------------------------
module dhkt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  dhkt_pkg::dp_status_t  stat,
    output dhkt_pkg::dp_cmd_t     cmd,
    output logic                  busy
);
    import dhkt_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_HASH  = 6'b000100,
        ST_INIT  = 6'b001000,
        ST_READ  = 6'b010000,
        ST_CHECK = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_status = STATUS_OK;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (stat.refuse)
                begin
                    cmd.finish     = 1'b1;
                    cmd.res_status = STATUS_FULL;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.hash_step = 1'b1;
                    if (stat.hash_last)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.probe_init = 1'b1;
                state_next     = ST_READ;
            end
            ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.slot_empty)
                begin
                    cmd.finish = 1'b1;
                    if (stat.is_search)
                    begin
                        cmd.res_status = STATUS_MISS;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else if (stat.slot_match)
                begin
                    cmd.finish = 1'b1;
                    if (stat.is_search)
                    begin
                        cmd.res_hit = 1'b1;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else if (stat.probe_last)
                begin
                    cmd.finish = 1'b1;
                    if (stat.is_search)
                    begin
                        cmd.res_status = STATUS_MISS;
                    end
                    else
                    begin
                        cmd.res_status = STATUS_FULL;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== rtl/double_hash_key_table_core.sv =====
// ----------------------------------------------------------------------------
// double_hash_key_table_core
// Open-addressing key/value table with double hashing, insert/update and
// search, no deletion.
//
//   channel  | ports                  | handshake
//   ---------+------------------------+-----------------------------------
//   request  | start, busy, request   | taken when start high, busy low
//   result   | result_valid, result   | one-cycle strobe, one per request
//
// A request passes through key reduction (reciprocal multiply, then
// remainder), probe set-up and, for each probe, a registered memory read
// and a check. Busy falls once the request is resolved, and the result
// strobe is high in the first cycle that busy is low.
// An insert into a full table is refused at the start of key reduction.
// After reset a clearing pass holds busy high until every slot is cleared.
// The result port cannot be stalled.
// ----------------------------------------------------------------------------
module double_hash_key_table_core #(
    parameter int TABLE_SLOTS = dhkt_pkg::TABLE_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  dhkt_pkg::request_t request,
    output logic               result_valid,
    output dhkt_pkg::result_t  result
);
    import dhkt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    dhkt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    dhkt_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== tb/tb_double_hash_key_table_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_hash_key_table_core
// Self-checking bench for the double-hashing key table. A queue of requests
// is driven with random idle gaps. A directed opening covers empty-table
// searches, key and value extremes, probe collisions and updates. A random
// part follows that draws keys mostly from those already stored or from a
// few colliding residue classes, so the table fills and then refuses inserts.
// A local table model predicts every result, and each strobed result is
// checked field by field in order.
// ----------------------------------------------------------------------------
module tb_double_hash_key_table_core;

    import dhkt_pkg::*;

    localparam int SLOTS           = TABLE_SLOTS_DEF;
    localparam int RANDOM_REQUESTS = 2000;
    localparam int DRAIN_CYCLES    = 300;
    localparam int TIMEOUT_NS      = 30_000_000;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    request_t request = '0;
    logic     result_valid;
    result_t  result;

    // request stream and expected results
    request_t request_q [$];
    int       request_gap_q [$];
    result_t  lookup_outcomes [$];
    logic [KEY_W-1:0] known_keys [$];
    bit       steady_run = 1'b0;
    int       fail_count = 0;

    // table model
    bit                 slot_used [SLOTS];
    logic [KEY_W-1:0]   slot_key  [SLOTS];
    logic [VALUE_W-1:0] slot_val  [SLOTS];
    int                 fill_count = 0;

    double_hash_key_table_core #(
        .TABLE_SLOTS (SLOTS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int find_slot(logic [KEY_W-1:0] key, bit for_insert);
        int idx;
        int stride;
        idx    = key % SLOTS;
        stride = 1 + key % (SLOTS - 1);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!slot_used[idx])
                return for_insert ? idx : -1;
            if (slot_key[idx] == key)
                return idx;
            idx += stride;
            if (idx >= SLOTS)
                idx -= SLOTS;
        end
        return -1;
    endfunction

    function automatic result_t apply_table_op(request_t req);
        result_t res;
        int      slot;
        res.status    = STATUS_OK;
        res.value_out = '0;
        if (req.mode == MODE_INSERT)
        begin
            if (fill_count >= SLOTS)
                res.status = STATUS_FULL;
            else
            begin
                slot = find_slot(req.key, 1'b1);
                if (slot < 0)
                    res.status = STATUS_FULL;
                else
                begin
                    if (!slot_used[slot])
                        fill_count++;
                    slot_used[slot] = 1'b1;
                    slot_key[slot]  = req.key;
                    slot_val[slot]  = req.value;
                end
            end
        end
        else
        begin
            slot = find_slot(req.key, 1'b0);
            if (slot < 0)
                res.status = STATUS_MISS;
            else
                res.value_out = slot_val[slot];
        end
        res.entries_used = ENTRIES_W'(fill_count);
        return res;
    endfunction

    function automatic int draw_gap();
        if ($urandom_range(0, 39) == 0)
            steady_run = !steady_run;
        return steady_run ? 0 : int'($urandom_range(0, 14));
    endfunction

    task automatic queue_request(logic op_mode, logic [KEY_W-1:0] key,
                                 logic [VALUE_W-1:0] value);
        request_t req;
        req.mode  = op_mode;
        req.key   = key;
        req.value = value;
        request_q.insert(request_q.size(), req);
        request_gap_q.insert(request_gap_q.size(), draw_gap());
        if (op_mode == MODE_INSERT)
            known_keys.insert(known_keys.size(), key);
    endtask

    // driver: with no gap, the next request goes out in the same edge as the previous is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
        end
        else
        begin
            if (start && !busy)
                lookup_outcomes.insert(lookup_outcomes.size(), apply_table_op(request));
            if (!start || !busy)
            begin
                if (request_q.size() == 0)
                    start <= 1'b0;
                else if (request_gap_q[0] > 0)
                begin
                    request_gap_q[0] = request_gap_q[0] - 1;
                    start <= 1'b0;
                end
                else
                begin
                    request <= request_q.pop_front();
                    void'(request_gap_q.pop_front());
                    start <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n && result_valid)
        begin
            if (lookup_outcomes.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result status=%0d value_out=%h entries=%0d",
                             $realtime, result.status, result.value_out,
                             result.entries_used);
            end
            else
            begin
                exp_res = lookup_outcomes.pop_front();
                if (result.status !== exp_res.status ||
                    result.value_out !== exp_res.value_out ||
                    result.entries_used !== exp_res.entries_used)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"%0t: mismatch status %0d/%0d value_out %h/%h",
                                  " entries %0d/%0d (exp/act)"},
                                 $realtime, exp_res.status, result.status,
                                 exp_res.value_out, result.value_out,
                                 exp_res.entries_used, result.entries_used);
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic               op_mode;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        int                 pick;

        // directed opening
        queue_request(MODE_SEARCH, 31'd0, 32'hFFFF_FFFF);
        queue_request(MODE_INSERT, 31'd0, 32'h0000_0000);
        queue_request(MODE_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_request(MODE_SEARCH, 31'd0, 32'h1234_5678);
        queue_request(MODE_SEARCH, 31'h7FFF_FFFF, 32'h0);
        // collision chain on one start slot
        queue_request(MODE_INSERT, 31'd5, 32'hAAAA_AAAA);
        queue_request(MODE_INSERT, 31'd5 + 31'd127, 32'h5555_5555);
        queue_request(MODE_INSERT, 31'd5 + 31'd254, 32'h0F0F_0F0F);
        queue_request(MODE_SEARCH, 31'd5 + 31'd254, 32'h0);
        queue_request(MODE_SEARCH, 31'd5 + 31'd381, 32'h0);
        // update keeps the count
        queue_request(MODE_INSERT, 31'd5 + 31'd127, 32'hDEAD_BEEF);
        queue_request(MODE_SEARCH, 31'd5 + 31'd127, 32'h0);
        queue_request(MODE_SEARCH, 31'd5, 32'h0);
        queue_request(MODE_INSERT, 31'd126, 32'h8000_0001);
        queue_request(MODE_INSERT, 31'd127, 32'h7FFF_FFFE);
        queue_request(MODE_SEARCH, 31'd127, 32'h0);
        queue_request(MODE_INSERT, 31'h2AAA_AAAA, 32'h3333_3333);
        queue_request(MODE_INSERT, 31'h5555_5555, 32'hCCCC_CCCC);
        queue_request(MODE_SEARCH, 31'h2AAA_AAAA, 32'h0);
        queue_request(MODE_SEARCH, 31'h5555_5555, 32'h0);
        queue_request(MODE_SEARCH, 31'h4000_0000, 32'h0);

        // random part: mostly stored keys and colliding residues
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            op_mode = $urandom_range(0, 1) ? MODE_SEARCH : MODE_INSERT;
            pick    = $urandom_range(0, 99);
            if (pick < 65 && known_keys.size() > 0)
                key = known_keys[$urandom_range(0, known_keys.size() - 1)];
            else if (pick < 88)
                key = KEY_W'($urandom_range(0, 7) * 17 +
                             127 * $urandom_range(0, 16_000_000));
            else if (pick < 91)
                key = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
            else
                key = KEY_W'($urandom);
            pick = $urandom_range(0, 19);
            if (pick == 0)
                value = '0;
            else if (pick == 1)
                value = '1;
            else
                value = $urandom;
            queue_request(op_mode, key, value);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || start)
            @(posedge clk);
        while (lookup_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (lookup_outcomes.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
